// ===== rtl/binary_to_decimal_ascii_top_defines.svh =====
// Assertion macros for the binary to decimal ASCII converter.
// Included by the top level; needs nothing else.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define B2DA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
`default_nettype none

package b2da_pkg;

   localparam int VALUE_WIDTH   = 32;
   // ceil(VALUE_WIDTH * log10(2)) decimal digits hold any magnitude
   localparam int NUM_DIGITS    = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH     = 4 * NUM_DIGITS;
   localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_CNT_WIDTH = $clog2(NUM_DIGITS + 1);
   localparam int IN_WIDTH      = 32;
   localparam int CHAR_WIDTH    = 6;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 6'd57;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [3:0]            DABBLE_LIMIT  = 4'd5;
   localparam logic [3:0]            DABBLE_ADJUST = 4'd3;

   typedef struct packed {
      logic [IN_WIDTH-1:0] value;
      logic                func;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] text_char;
      logic                  last_char;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic shift_digit;
      logic put_sign;
      logic put_digit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic negative;
      logic top_zero;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Channel  Ports                                  Carries
// req      req_valid, req_ready, req_payload      word and signed/unsigned mode
// rsp      rsp_valid, rsp_ready, rsp_payload      one ASCII character, last mark
//
// One transaction at a time. Accept cycle loads the magnitude, then VALUE_WIDTH
// (32) double dabble shifts, a strip step that drops leading zeros (0..9),
// then one character per cycle (1..11) while the output is not stalled.
// Output stalls hold emission only; a new word is taken while the final
// character still waits in the output register. Synchronous reset returns
// the controller to idle.
//
// Depends on b2da_pkg, b2da_ctrl, b2da_dp and the defines header.
`default_nettype none
`include "binary_to_decimal_ascii_top_defines.svh"

module binary_to_decimal_ascii_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire b2da_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output b2da_pkg::rsp_payload_type      rsp_payload
);

   b2da_pkg::cmd_type    cmd;
   b2da_pkg::status_type status;

   b2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   b2da_dp u_dp (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   `B2DA_ASSERT_NOW(a_char_range, clock, reset, rsp_valid,
      (rsp_payload.text_char == b2da_pkg::CHAR_MINUS) ||
      ((rsp_payload.text_char >= b2da_pkg::CHAR_ZERO) &&
       (rsp_payload.text_char <= b2da_pkg::CHAR_NINE)),
      "result character outside '-' and digits")
   `B2DA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready, "input taken again before conversion")
   `B2DA_ASSERT_NEXT(a_sign_output, clock, reset, cmd.put_sign,
      rsp_valid && (rsp_payload.text_char == b2da_pkg::CHAR_MINUS) &&
      !rsp_payload.last_char, "minus sign not presented correctly")
   `B2DA_ASSERT_NOW(a_single_command, clock, reset, cmd.load || cmd.dabble,
      !cmd.put_digit && !cmd.put_sign && !cmd.shift_digit, "conversion overlaps emission")

endmodule

`default_nettype wire

// ===== rtl/b2da_dp.sv =====
// Datapath: sign handling, double dabble shift register and output register.
// Depends on b2da_pkg.
`default_nettype none

module b2da_dp (
   input  wire logic                      clock,
   input  wire b2da_pkg::req_payload_type req_payload,
   input  wire b2da_pkg::cmd_type         cmd,
   output b2da_pkg::status_type           status,
   output b2da_pkg::rsp_payload_type      rsp_payload
);

   logic [b2da_pkg::VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [b2da_pkg::BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic                             neg_ff, neg_in;
   logic [b2da_pkg::CHAR_WIDTH-1:0]  text_ff, text_in;
   logic                             last_ff, last_in;
   logic [b2da_pkg::BCD_WIDTH-1:0]   adj;
   logic [3:0]                       top_digit;

   assign top_digit = bcd_ff[b2da_pkg::BCD_WIDTH-1 -: 4];

   // add three to every digit of five or more before the shift
   always_comb begin
      logic [3:0] digit;
      adj = '0;
      for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
         digit = bcd_ff[4*i +: 4];
         adj[4*i +: 4] = (digit >= b2da_pkg::DABBLE_LIMIT) ?
                         digit + b2da_pkg::DABBLE_ADJUST : digit;
      end
   end

   always_comb begin
      logic [b2da_pkg::VALUE_WIDTH-1:0] word;
      logic                             neg;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      text_in = text_ff;
      last_in = last_ff;
      word    = b2da_pkg::VALUE_WIDTH'(req_payload.value);
      neg     = !req_payload.func && word[b2da_pkg::VALUE_WIDTH-1];
      if (cmd.load) begin
         // two's complement negation; the most negative word is its own magnitude
         bin_in = neg ? (~word + 1'b1) : word;
         bcd_in = '0;
         neg_in = neg;
      end else if (cmd.dabble) begin
         {bcd_in, bin_in} = {adj, bin_ff} << 1;
      end else if (cmd.shift_digit) begin
         bcd_in = bcd_ff << 4;
      end
      if (cmd.put_sign) begin
         text_in = b2da_pkg::CHAR_MINUS;
         last_in = 1'b0;
      end else if (cmd.put_digit) begin
         text_in = b2da_pkg::CHAR_ZERO + {2'b00, top_digit};
         last_in = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      text_ff <= text_in;
      last_ff <= last_in;
   end

   assign status.negative      = neg_ff;
   assign status.top_zero      = (top_digit == 4'd0);
   assign rsp_payload.text_char = text_ff;
   assign rsp_payload.last_char = last_ff;

endmodule

`default_nettype wire

// ===== rtl/b2da_ctrl.sv =====
// Controller: sequences load, conversion, leading zero strip and emission.
// Depends on b2da_pkg.
`default_nettype none

module b2da_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire b2da_pkg::status_type status,
   output b2da_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type                            state_ff, state_in;
   logic [b2da_pkg::CNT_WIDTH-1:0]       count_ff, count_in;
   logic [b2da_pkg::DIG_CNT_WIDTH-1:0]   digits_ff, digits_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      digits_in    = digits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = b2da_pkg::CNT_WIDTH'(b2da_pkg::VALUE_WIDTH);
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            count_in   = count_ff - 1'b1;
            if (count_ff == b2da_pkg::CNT_WIDTH'(1)) begin
               digits_in = b2da_pkg::DIG_CNT_WIDTH'(b2da_pkg::NUM_DIGITS);
               state_in  = ST_STRIP;
            end
         end
         ST_STRIP: begin
            // drop leading zeros, keeping at least one digit
            if (status.top_zero && digits_ff != b2da_pkg::DIG_CNT_WIDTH'(1)) begin
               cmd.shift_digit = 1'b1;
               digits_in       = digits_ff - 1'b1;
            end else begin
               state_in = status.negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               cmd.put_sign = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               cmd.put_digit   = 1'b1;
               cmd.shift_digit = 1'b1;
               cmd.last        = (digits_ff == b2da_pkg::DIG_CNT_WIDTH'(1));
               rsp_valid_in    = 1'b1;
               digits_in       = digits_ff - 1'b1;
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         digits_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         digits_ff    <= digits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for binary_to_decimal_ascii_top: words go in, ASCII digits come out.
// Predicts each word's decimal text and compares it character by character.
// Depends on b2da_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam logic FUNC_SIGNED   = 1'b0;
   localparam logic FUNC_UNSIGNED = 1'b1;
   localparam int   DECIMAL_BASE  = 10;
   localparam int   RANDOM_WORDS  = 470;
   localparam int   SETTLE_CYCLES = 80;
   localparam int   CYCLE_LIMIT   = 1000000;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_ALTERNATE
   } ready_pattern_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   b2da_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   b2da_pkg::rsp_payload_type rsp_payload;

   b2da_pkg::req_payload_type pending_words[$];
   b2da_pkg::rsp_payload_type expected_chars[$];
   b2da_pkg::rsp_payload_type wanted_char;

   int words_total;
   int words_accepted;
   int signed_words;
   int negative_words;
   int chars_checked;
   int longest_text;
   int failures;
   int cycle_count;

   // sender burst state
   int burst_left;
   int gap_left;

   // receiver stall state
   ready_pattern_type ready_pattern;
   int                pattern_left;
   logic [2:0]        pattern_phase;

   binary_to_decimal_ascii_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Work out the decimal text of one word and queue its characters.
   function automatic void spell_decimal(input b2da_pkg::req_payload_type word);
      logic [b2da_pkg::VALUE_WIDTH:0]  magnitude;
      logic [3:0]                      digit;
      logic [b2da_pkg::CHAR_WIDTH-1:0] reversed[$];
      logic                            negative;
      b2da_pkg::rsp_payload_type       text;
      int                              length;
      negative = (word.func == FUNC_SIGNED) && word.value[b2da_pkg::VALUE_WIDTH-1];
      // one bit wider than the word, so the most negative value fits
      if (negative) begin
         magnitude = {1'b0, ~word.value[b2da_pkg::VALUE_WIDTH-1:0]} + 1'b1;
      end else begin
         magnitude = {1'b0, word.value[b2da_pkg::VALUE_WIDTH-1:0]};
      end
      do begin
         digit = 4'(magnitude % DECIMAL_BASE);
         reversed.push_back(b2da_pkg::CHAR_ZERO + digit);
         magnitude = magnitude / DECIMAL_BASE;
      end while (magnitude != 0);
      length = reversed.size();
      if (negative) begin
         text.text_char = b2da_pkg::CHAR_MINUS;
         text.last_char = 1'b0;
         expected_chars.push_back(text);
         length++;
         negative_words++;
      end
      while (reversed.size() > 0) begin
         text.text_char = reversed.pop_back();
         text.last_char = (reversed.size() == 0);
         expected_chars.push_back(text);
      end
      if (word.func == FUNC_SIGNED) signed_words++;
      if (length > longest_text) longest_text = length;
   endfunction

   function automatic b2da_pkg::req_payload_type random_word();
      b2da_pkg::req_payload_type word;
      longint unsigned           power;
      int                        bits;
      int                        shape;
      word.func = 1'($urandom_range(0, 1));
      shape = $urandom_range(0, 9);
      if (shape <= 2) begin
         word.value = $urandom;
      end else if (shape <= 5) begin
         // random bit length spreads the digit count
         bits = $urandom_range(1, b2da_pkg::VALUE_WIDTH);
         word.value = 32'((64'($urandom)) & ((64'd1 << bits) - 1));
         if ($urandom_range(0, 1)) word.value = -word.value;
      end else if (shape <= 7) begin
         // straddle a power of ten
         power = 1;
         repeat ($urandom_range(0, 9)) power = power * DECIMAL_BASE;
         word.value = 32'(power) + 32'($urandom_range(0, 4)) - 32'd2;
         if ($urandom_range(0, 1)) word.value = -word.value;
      end else if (shape == 8) begin
         case ($urandom_range(0, 4))
            0: word.value = 32'h0000_0000;
            1: word.value = 32'h7FFF_FFFF;
            2: word.value = 32'h8000_0000;
            3: word.value = 32'hFFFF_FFFF;
            default: word.value = 32'h8000_0001;
         endcase
      end else begin
         word.value = 32'($urandom_range(0, 20));
         if ($urandom_range(0, 1)) word.value = -word.value;
      end
      return word;
   endfunction

   function automatic void add_word(input logic [b2da_pkg::IN_WIDTH-1:0] value,
                                    input logic func);
      b2da_pkg::req_payload_type word;
      word.value = value;
      word.func  = func;
      pending_words.push_back(word);
   endfunction

   // Driver: send pending words in bursts, predicting on each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 12);
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            spell_decimal(req_payload);
            words_accepted++;
         end
         // hold the payload while the transaction waits
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_payload <= pending_words.pop_front();
               req_valid   <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switch between stall patterns every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         ready_pattern = READY_ALWAYS;
         pattern_left  = 0;
         pattern_phase = '0;
      end else begin
         if (pattern_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(20, 200);
         end else begin
            pattern_left--;
         end
         case (ready_pattern)
            READY_ALWAYS:    rsp_ready <= 1'b1;
            READY_RANDOM:    rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:    rsp_ready <= (pattern_phase == 3'd0);
            default:         rsp_ready <= pattern_phase[0];
         endcase
         pattern_phase++;
      end
   end

   // Monitor: compare every accepted character with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character: text_char %0d, last_char %0b",
                   rsp_payload.text_char, rsp_payload.last_char);
            failures++;
         end else begin
            wanted_char = expected_chars.pop_front();
            chars_checked++;
            if (rsp_payload.text_char !== wanted_char.text_char) begin
               $error("text_char: expected %0d, got %0d",
                      wanted_char.text_char, rsp_payload.text_char);
               failures++;
            end
            if (rsp_payload.last_char !== wanted_char.last_char) begin
               $error("last_char: expected %0b, got %0b",
                      wanted_char.last_char, rsp_payload.last_char);
               failures++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      words_accepted = 0;
      signed_words   = 0;
      negative_words = 0;
      chars_checked  = 0;
      longest_text   = 0;
      failures       = 0;
      cycle_count    = 0;

      // zero, unit, sign boundaries and digit-count steps
      add_word(32'd0, FUNC_SIGNED);
      add_word(32'd0, FUNC_UNSIGNED);
      add_word(32'd1, FUNC_SIGNED);
      add_word(32'hFFFF_FFFF, FUNC_SIGNED);
      add_word(32'hFFFF_FFFF, FUNC_UNSIGNED);
      add_word(32'h8000_0000, FUNC_SIGNED);
      add_word(32'h8000_0000, FUNC_UNSIGNED);
      add_word(32'h7FFF_FFFF, FUNC_SIGNED);
      add_word(32'h7FFF_FFFF, FUNC_UNSIGNED);
      add_word(32'h8000_0001, FUNC_SIGNED);
      add_word(32'd9, FUNC_UNSIGNED);
      add_word(32'd10, FUNC_SIGNED);
      add_word(32'd99, FUNC_SIGNED);
      add_word(32'd100, FUNC_UNSIGNED);
      add_word(32'd999_999_999, FUNC_SIGNED);
      add_word(32'd1_000_000_000, FUNC_UNSIGNED);
      add_word(-32'd9, FUNC_SIGNED);
      add_word(-32'd10, FUNC_SIGNED);
      add_word(-32'd1_000_000_000, FUNC_SIGNED);
      add_word(32'd4_000_000_000, FUNC_UNSIGNED);
      add_word(32'd123_456_789, FUNC_SIGNED);
      add_word(32'hAAAA_AAAA, FUNC_UNSIGNED);
      add_word(32'h5555_5555, FUNC_SIGNED);
      repeat (RANDOM_WORDS) pending_words.push_back(random_word());
      words_total = pending_words.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < words_total) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      // let any stray character show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d words (%0d signed, %0d negative); %0d characters checked.",
               words_accepted, signed_words, negative_words, chars_checked);
      $display("Longest text seen: %0d characters.", longest_text);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_dp.sv
rtl/b2da_ctrl.sv
rtl/binary_to_decimal_ascii_top.sv
tb/sv/tb_top.sv
